@@ src/nmea_gga_field_extractor_core_macros.svh @@
// Assertion macros for the GGA field extractor, used by ngfe_parser.
// Each macro expands to one labeled concurrent assertion on a clock and reset.
`ifndef NMEA_GGA_FIELD_EXTRACTOR_CORE_MACROS_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_CORE_MACROS_SVH

// Same-cycle implication.
`define NGFE_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NGFE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ngfe_pkg.sv @@
// Shared types, constants and helper functions for the GGA field extractor.
// Used by ngfe_parser and nmea_gga_field_extractor_core; depends on nothing.
`timescale 1ns / 1ps

package ngfe_pkg;

  localparam int unsigned MAX_FIELD_CHARS_DEF = 10;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_A      = 8'h41;

  localparam logic [2:0] HEADER_LEN  = 3'd5;
  localparam logic [2:0] COMMA_MAX   = 3'd7;
  localparam logic [2:0] FIRST_FIELD = 3'd1;
  localparam logic [2:0] LAST_FIELD  = 3'd5;
  localparam logic [2:0] FID_END     = 3'd5;

  typedef struct packed {
    logic [2:0] field_id;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    logic       last;
  } ngfe_result_t;

  // Expected header character at each position of "GPGGA".
  function automatic logic [7:0] gga_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = CHAR_G;
      3'd1: c = CHAR_P;
      3'd2: c = CHAR_G;
      3'd3: c = CHAR_G;
      3'd4: c = CHAR_A;
      default: c = CHAR_A;
    endcase
    return c;
  endfunction

endpackage

@@ src/ngfe_parser.sv @@
// Sentence tracking state and the per-word decode for the GGA field extractor.
// Depends on ngfe_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "nmea_gga_field_extractor_core_macros.svh"

module ngfe_parser
  import ngfe_pkg::*;
#(
  parameter int unsigned MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [7:0]   byte_in,
  output logic         hit,
  output ngfe_result_t result
);

  logic       in_sentence, in_sentence_next;
  logic [2:0] header_pos, header_pos_next;
  logic       header_match, header_match_next;
  logic [2:0] comma_count, comma_count_next;
  logic [3:0] char_index, char_index_next;

  always_comb begin
    in_sentence_next  = in_sentence;
    header_pos_next   = header_pos;
    header_match_next = header_match;
    comma_count_next  = comma_count;
    char_index_next   = char_index;
    hit               = 1'b0;
    result            = '0;
    if (!in_sentence) begin
      if (byte_in == CHAR_DOLLAR) begin
        in_sentence_next  = 1'b1;
        header_pos_next   = '0;
        header_match_next = 1'b1;
        comma_count_next  = '0;
        char_index_next   = '0;
      end
    end else if (byte_in == CHAR_STAR) begin
      in_sentence_next  = 1'b0;
      header_pos_next   = '0;
      header_match_next = 1'b1;
      comma_count_next  = '0;
      char_index_next   = '0;
      hit               = (header_pos == HEADER_LEN) && header_match;
      result.field_id   = FID_END;
      result.last       = 1'b1;
    end else if (header_pos < HEADER_LEN) begin
      if (byte_in != gga_char(header_pos)) begin
        header_match_next = 1'b0;
      end
      header_pos_next = header_pos + 3'd1;
    end else if (byte_in == CHAR_COMMA) begin
      if (comma_count != COMMA_MAX) begin
        comma_count_next = comma_count + 3'd1;
      end
      char_index_next = '0;
    end else if (header_match && comma_count >= FIRST_FIELD && comma_count <= LAST_FIELD &&
                 char_index < 4'(MAX_FIELD_CHARS)) begin
      hit               = 1'b1;
      result.field_id   = comma_count - FIRST_FIELD;
      result.char_pos   = char_index;
      result.char_value = byte_in;
      char_index_next   = char_index + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence  <= 1'b0;
      header_pos   <= '0;
      header_match <= 1'b1;
      comma_count  <= '0;
      char_index   <= '0;
    end else if (fire) begin
      in_sentence  <= in_sentence_next;
      header_pos   <= header_pos_next;
      header_match <= header_match_next;
      comma_count  <= comma_count_next;
      char_index   <= char_index_next;
    end
  end

  `NGFE_ASSERT_NOW(a_index_bound, clk, rst, 1'b1, char_index <= 4'(MAX_FIELD_CHARS), "char index past limit")
  `NGFE_ASSERT_NOW(a_header_bound, clk, rst, 1'b1, header_pos <= HEADER_LEN, "header position past length")
  `NGFE_ASSERT_NOW(a_hunt_clean, clk, rst, !in_sentence, comma_count == 3'd0 && char_index == 4'd0 && header_pos == 3'd0, "stale sentence state while hunting")
  `NGFE_ASSERT_NOW(a_hunt_silent, clk, rst, !in_sentence, !hit, "result produced while hunting")

endmodule

@@ src/nmea_gga_field_extractor_core.sv @@
// Top level of the GGA field extractor: input register, parser, result register.
// Depends on ngfe_pkg and ngfe_parser.
`timescale 1ns / 1ps

// The input channel carries one received serial byte per word on rx_byte, with
// in_valid and in_stall. The output channel carries one extracted character per
// word: field_id, char_pos, char_value and last, with out_valid and out_stall.
// A byte is held in an input register, decoded combinationally against the
// sentence state, and any result is loaded into the output register. A new
// byte is taken every cycle while in_stall is low; bytes that give no result
// are consumed silently. The output register and the input register are the
// only buffering: when the receiver stalls with a result waiting, the held
// byte stays in the input register and in_stall rises until the result is
// taken. Reset clears both valid flags and returns the parser to hunting for
// the start of a sentence. Only sentences whose header reads GPGGA produce
// words: the characters of the time, latitude, N/S, longitude and E/W fields,
// then an end word with last high at the asterisk.
module nmea_gga_field_extractor_core
  import ngfe_pkg::*;
#(
  parameter int unsigned MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] field_id,
  output logic [3:0] char_pos,
  output logic [7:0] char_value,
  output logic       last
);

  logic         in_full;
  logic [7:0]   byte_reg;
  logic         out_free;
  logic         advance;
  logic         hit;
  ngfe_result_t result;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;

  ngfe_parser #(
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .byte_in(byte_reg),
    .hit    (hit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_reg <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      field_id   <= result.field_id;
      char_pos   <= result.char_pos;
      char_value <= result.char_value;
      last       <= result.last;
    end
  end

endmodule
